### rtl/core/frt_pkg.sv
// Frame rate tracker: shared widths, constants and outcome codes.
// No dependencies; used by every module of the block.
package frt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int PERIOD_BITS = 20;

  // Smoothed rate is Q10.FRAC_BITS.
  localparam int SMOOTH_W = 10 + FRAC_BITS;
  // 1e6 fits in 20 bits, so the scaled numerator needs 20 + FRAC_BITS.
  localparam int NUM_W    = 20 + FRAC_BITS;
  localparam int NUM_CW   = $clog2(NUM_W);

  // Smoothing weight 3277/65536, walked one multiplier bit a cycle.
  localparam int ALPHA_W  = 12;
  localparam int ALPHA_CW = $clog2(ALPHA_W);
  localparam int PROD_W   = SMOOTH_W + ALPHA_W;
  localparam logic [ALPHA_W-1:0] ALPHA_NUM = ALPHA_W'(3277);
  localparam logic [PROD_W-1:0]  STEP_RND  = PROD_W'(32768);
  localparam int STEP_SHIFT = 16;

  localparam logic [NUM_W-1:0] DIV_NUM  = NUM_W'(1000000) << FRAC_BITS;
  localparam logic [NUM_W-1:0] RATE_SAT = NUM_W'(1023) << FRAC_BITS;

  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = PERIOD_BITS'(500000);

  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE  = SMOOTH_W'(1) << FRAC_BITS;
  localparam logic [SMOOTH_W-1:0] SMOOTH_TOP  = SMOOTH_W'(1000) << FRAC_BITS;
  localparam logic [SMOOTH_W:0]   SMOOTH_HALF = (SMOOTH_W + 1)'(1) << (FRAC_BITS - 1);

  localparam int RND_W = SMOOTH_W - FRAC_BITS + 1;
  localparam logic [RND_W-1:0] RATE_LO = RND_W'(10);
  localparam logic [RND_W-1:0] RATE_HI = RND_W'(240);

  localparam logic [31:0] ADDR_LO = 32'h0010_0000;
  localparam logic [31:0] ADDR_HI = 32'h0200_0000;

  typedef enum logic [2:0] {
    OUT_APPLIED    = 3'd0,
    OUT_BAD_PERIOD = 3'd1,
    OUT_DISABLED   = 3'd2,
    OUT_DEADBAND   = 3'd3,
    OUT_BAD_ADDR   = 3'd4
  } outcome_e;

endpackage

### rtl/core/frt_div.sv
// Frame rate tracker: bit-serial restoring divider, (1e6 << FRAC_BITS) / period.
// Depends on frt_pkg. One quotient bit per cycle, saturated result.
module frt_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [frt_pkg::PERIOD_BITS-1:0]     divisor_i,
  output logic                                done_o,
  output logic [frt_pkg::SMOOTH_W-1:0]        quot_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [frt_pkg::NUM_CW-1:0]        cnt_q;
  logic [frt_pkg::PERIOD_BITS-1:0]   rem_q;
  logic [frt_pkg::PERIOD_BITS-1:0]   div_q;
  logic [frt_pkg::NUM_W-1:0]         quo_q;
  logic [frt_pkg::SMOOTH_W-1:0]      quot_q;

  logic [frt_pkg::PERIOD_BITS:0]     trial;
  logic                              ge;
  logic [frt_pkg::PERIOD_BITS-1:0]   rem_d;
  logic [frt_pkg::NUM_W-1:0]         quo_d;

  always_comb begin
    trial = {rem_q, frt_pkg::DIV_NUM[cnt_q]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? frt_pkg::PERIOD_BITS'(trial - {1'b0, div_q})
               : trial[frt_pkg::PERIOD_BITS-1:0];
    quo_d = {quo_q[frt_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= frt_pkg::NUM_CW'(frt_pkg::NUM_W - 1);
        rem_q  <= '0;
        div_q  <= divisor_i;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          quot_q <= (quo_d > frt_pkg::RATE_SAT) ? frt_pkg::RATE_SAT[frt_pkg::SMOOTH_W-1:0]
                                               : quo_d[frt_pkg::SMOOTH_W-1:0];
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/core/frt_mul.sv
// Frame rate tracker: bit-serial multiply of the rate gap by the smoothing weight.
// Depends on frt_pkg. MSB-first shift-and-add, one weight bit per cycle.
module frt_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [frt_pkg::SMOOTH_W-1:0]   mag_i,
  output logic                           done_o,
  output logic [frt_pkg::PROD_W-1:0]     prod_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [frt_pkg::ALPHA_CW-1:0]     cnt_q;
  logic [frt_pkg::SMOOTH_W-1:0]     mag_q;
  logic [frt_pkg::PROD_W-1:0]       acc_q;
  logic [frt_pkg::PROD_W-1:0]       acc_d;

  always_comb begin
    acc_d = (acc_q << 1)
          + (frt_pkg::ALPHA_NUM[cnt_q] ? frt_pkg::PROD_W'(mag_q) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mag_q  <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= frt_pkg::ALPHA_CW'(frt_pkg::ALPHA_W - 1);
        mag_q  <= mag_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        acc_q <= acc_d;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### rtl/core/frame_rate_tracker_with_deadband_unit.sv
// Frame rate tracker with deadband: top level, sequencer and output register.
// Depends on frt_pkg, frt_div and frt_mul.
//
//  channel   | direction | beat fields (lowest bit up)
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | frame_period_us[19:0], target_address[51:20], pad
//  m_axis    | out       | outcome[2:0], rate_value[10:3], smoothed_rate[36:11], pad
//  cfg       | in        | tracking_enable (cfg_data_i), always ready
//
//  A tracked beat passes a check, a serial divide (one quotient bit per
//  cycle), a hand-off and a serial multiply, then step, add, rate and emit
//  steps. Bad period or disabled beats go from the check straight to emit.
//  Input is ready again on the edge that loads the result, so a new beat is
//  taken only once the last tracked beat's result has been loaded.
//  Reset clears the smoothed and applied rates and sets tracking_enable.
//  One beat is in flight at a time; a result waiting in the output register
//  does not stop the next beat being accepted, only its own result is held.
module frame_rate_tracker_with_deadband_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // frame_period_us[19:0], target_address[51:20], zeros[55:52]
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // outcome[2:0], rate_value[10:3], smoothed_rate[36:11], zeros[39:37]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_DIV,
    ST_MUL,
    ST_STEP,
    ST_ADD,
    ST_RATE,
    ST_EMIT
  } state_e;

  state_e                             state_q;
  logic                               enable_q;
  logic [frt_pkg::PERIOD_BITS-1:0]    period_q;
  logic [31:0]                        addr_q;
  logic [frt_pkg::SMOOTH_W-1:0]       smooth_q;
  logic [7:0]                         applied_q;
  logic [frt_pkg::SMOOTH_W-1:0]       base_q;
  logic                               up_q;
  logic [frt_pkg::SMOOTH_W-1:0]       step_q;
  frt_pkg::outcome_e                  outcome_q;
  logic [7:0]                         rate_q;
  logic                               m_valid_q;
  logic [39:0]                        m_data_q;

  logic                               div_start;
  logic                               div_done;
  logic [frt_pkg::SMOOTH_W-1:0]       div_now;
  logic                               mul_start;
  logic                               mul_done;
  logic [frt_pkg::PROD_W-1:0]         mul_prod;

  // Start-of-smoothing values
  logic                               reinit;
  logic [frt_pkg::SMOOTH_W-1:0]       base_d;
  logic                               up_d;
  logic [frt_pkg::SMOOTH_W-1:0]       mag_d;

  // Rounding, clamp and apply decision
  logic [frt_pkg::SMOOTH_W:0]         rnd_sum;
  logic [frt_pkg::RND_W-1:0]          rnd;
  logic [7:0]                         rate_d;
  logic                               in_band;
  logic                               addr_bad;
  logic                               period_bad;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  assign div_start = (state_q == ST_CHK) && !period_bad && enable_q;
  assign mul_start = (state_q == ST_DIV) && div_done;

  always_comb begin
    period_bad = (period_q == '0) || (period_q > frt_pkg::PERIOD_MAX);

    // A stored rate outside 1..1000 Hz restarts from the fresh measurement.
    reinit = (smooth_q < frt_pkg::SMOOTH_ONE) || (smooth_q > frt_pkg::SMOOTH_TOP);
    base_d = reinit ? div_now : smooth_q;
    up_d   = div_now >= base_d;
    mag_d  = up_d ? (div_now - base_d) : (base_d - div_now);

    rnd_sum = {1'b0, smooth_q} + frt_pkg::SMOOTH_HALF;
    rnd     = rnd_sum[frt_pkg::SMOOTH_W:frt_pkg::FRAC_BITS];
    if (rnd < frt_pkg::RATE_LO) begin
      rate_d = frt_pkg::RATE_LO[7:0];
    end else if (rnd > frt_pkg::RATE_HI) begin
      rate_d = frt_pkg::RATE_HI[7:0];
    end else begin
      rate_d = rnd[7:0];
    end

    // Deadband: less than 2 Hz from the last applied rate.
    in_band = (applied_q != 8'd0)
           && ((rate_d == applied_q) || (rate_d == applied_q + 8'd1)
               || (applied_q == rate_d + 8'd1));
    addr_bad = (addr_q < frt_pkg::ADDR_LO) || (addr_q >= frt_pkg::ADDR_HI)
            || (addr_q[1:0] != 2'b00);
  end

  frt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (period_q),
    .done_o    (div_done),
    .quot_o    (div_now)
  );

  frt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mag_i   (mag_d),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      enable_q  <= 1'b1;
      period_q  <= '0;
      addr_q    <= '0;
      smooth_q  <= '0;
      applied_q <= '0;
      base_q    <= '0;
      up_q      <= 1'b0;
      step_q    <= '0;
      outcome_q <= frt_pkg::OUT_APPLIED;
      rate_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        enable_q <= cfg_data_i;
      end

      // The emit step handles the output register itself.
      if (m_valid_q && m_axis_tready && (state_q != ST_EMIT)) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            period_q <= frt_pkg::PERIOD_BITS'(s_axis_tdata[19:0]);
            addr_q   <= s_axis_tdata[51:20];
            state_q  <= ST_CHK;
          end
        end
        ST_CHK: begin
          rate_q <= applied_q;
          if (period_bad) begin
            outcome_q <= frt_pkg::OUT_BAD_PERIOD;
            state_q   <= ST_EMIT;
          end else if (!enable_q) begin
            outcome_q <= frt_pkg::OUT_DISABLED;
            state_q   <= ST_EMIT;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            base_q  <= base_d;
            up_q    <= up_d;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          step_q  <= frt_pkg::SMOOTH_W'((mul_prod + frt_pkg::STEP_RND) >> frt_pkg::STEP_SHIFT);
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          smooth_q <= up_q ? (base_q + step_q) : (base_q - step_q);
          state_q  <= ST_RATE;
        end
        ST_RATE: begin
          if (in_band) begin
            outcome_q <= frt_pkg::OUT_DEADBAND;
            rate_q    <= applied_q;
          end else if (addr_bad) begin
            outcome_q <= frt_pkg::OUT_BAD_ADDR;
            rate_q    <= applied_q;
          end else begin
            outcome_q <= frt_pkg::OUT_APPLIED;
            rate_q    <= rate_d;
            applied_q <= rate_d;
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {3'b000, smooth_q, rate_q, outcome_q};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Applied rate is either "none yet" or inside the clamp window.
  a_applied_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (applied_q == 8'd0) || ((applied_q >= 8'd10) && (applied_q <= 8'd240)))
    else $error("applied rate outside clamp window");

  // Divider completion only arrives while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider done outside divide step");

  // Multiplier completion only arrives while the sequencer waits for it.
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL))
    else $error("multiplier done outside multiply step");

  // Smoothed rate only moves in the update step.
  a_smooth_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ADD) |=> $stable(smooth_q))
    else $error("smoothed rate changed outside update step");

endmodule
